// ===== design/hctb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hctb_pkg: shared types and constants of the Huffman code table builder
// Sizes of the node store, controller states and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package hctb_pkg;

  localparam int MAX_SYMBOLS  = 16;
  localparam int WEIGHT_BITS  = 24;
  localparam int NODE_COUNT   = 2 * MAX_SYMBOLS - 1;
  localparam int NODE_W       = $clog2(NODE_COUNT);
  localparam int LEAF_W       = $clog2(MAX_SYMBOLS);
  localparam int CNT_W        = $clog2(MAX_SYMBOLS + 1);
  localparam int SUM_W        = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
  localparam int SYM_W        = 8;
  localparam int CODE_W       = 15;
  localparam int LEN_W        = 4;
  localparam int CODE_MAX_LEN = 15;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_MERGE,
    ST_WALK,
    ST_EMIT
  } hctb_state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic merge;
    logic first_leaf;
    logic walk;
    logic next_leaf;
    logic finish;
  } hctb_cmd_t;

  typedef struct packed {
    logic build_done;
    logic scan_last;
    logic at_root;
    logic last_leaf;
  } hctb_status_t;

endpackage

// ===== design/hctb_sym_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hctb_sym_if: symbol/weight input channel
// Valid/ready channel carrying one (symbol, weight) pair per transaction.
// ----------------------------------------------------------------------------
interface hctb_sym_if import hctb_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [SYM_W-1:0]       symbol;
  logic [WEIGHT_BITS-1:0] weight;
  logic                   last_symbol;

  modport source (output valid, symbol, weight, last_symbol, input ready);
  modport sink   (input valid, symbol, weight, last_symbol, output ready);
endinterface

// ===== design/hctb_code_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hctb_code_if: code table output channel
// Valid/ready channel carrying one code table entry per transaction.
// ----------------------------------------------------------------------------
interface hctb_code_if import hctb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SYM_W-1:0]  out_symbol;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;
  logic              last_code;

  modport source (output valid, out_symbol, code_bits, code_length, last_code, input ready);
  modport sink   (input valid, out_symbol, code_bits, code_length, last_code, output ready);
endinterface

// ===== design/hctb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hctb_ctrl: sequencer of the code table builder
// Steps through loading, minimum scans, merges, tree walks and emission.
// ----------------------------------------------------------------------------
module hctb_ctrl import hctb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_last_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  hctb_status_t status_i,
  output hctb_cmd_t    cmd_o
);

  hctb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i && in_last_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.build_done) state_d = ST_WALK;
        else if (status_i.scan_last) state_d = ST_MERGE;
      end
      ST_MERGE: state_d = ST_SCAN;
      ST_WALK: begin
        if (status_i.at_root) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          state_d = status_i.last_leaf ? ST_LOAD : ST_WALK;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.first_leaf = status_i.build_done;
        cmd_o.scan       = !status_i.build_done;
      end
      ST_MERGE: cmd_o.merge = 1'b1;
      ST_WALK:  cmd_o.walk  = !status_i.at_root;
      ST_EMIT: begin
        out_valid_o     = 1'b1;
        cmd_o.next_leaf = out_ready_i && !status_i.last_leaf;
        cmd_o.finish    = out_ready_i && status_i.last_leaf;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/hctb_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hctb_dpath: node store and arithmetic of the code table builder
// Holds leaves and merged nodes, runs the two-minimum scan, the merge and
// the leaf-to-root walk that assembles each code.
// ----------------------------------------------------------------------------
module hctb_dpath import hctb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hctb_cmd_t              cmd_i,
  output hctb_status_t           status_o,
  input  logic [SYM_W-1:0]       symbol_i,
  input  logic [WEIGHT_BITS-1:0] weight_i,
  input  logic                   last_symbol_i,
  output logic [SYM_W-1:0]       out_symbol_o,
  output logic [CODE_W-1:0]      code_bits_o,
  output logic [LEN_W-1:0]       code_length_o,
  output logic                   last_code_o
);

  logic [SUM_W-1:0]  weight_mem [NODE_COUNT];
  logic [NODE_W-1:0] parent_q   [NODE_COUNT];
  logic [NODE_W-1:0] left_mem   [MAX_SYMBOLS-1];
  logic [SYM_W-1:0]  sym_mem    [MAX_SYMBOLS];

  logic [CNT_W-1:0]  leaf_cnt_q;
  logic [NODE_W-1:0] k_q, idx_q, a_q, b_q, child_q, par_q;
  logic [SUM_W-1:0]  wa_q, wb_q;
  logic              ha_q, hb_q;
  logic [LEAF_W-1:0] leaf_q;
  logic [CODE_W-1:0] code_q;
  logic [LEN_W-1:0]  len_q;

  logic              room;
  logic [CNT_W-1:0]  n_next;
  logic [LEAF_W-1:0] leaf_d;
  logic [NODE_W-1:0] rd_addr, rd_parent, rel;
  logic [SUM_W-1:0]  rd_weight;
  logic              bit_v;

  function automatic logic [LEAF_W-1:0] rel_k();
    logic [NODE_W-1:0] d;
    d = k_q - NODE_W'(leaf_cnt_q);
    return d[LEAF_W-1:0];
  endfunction

  assign room   = leaf_cnt_q < CNT_W'(MAX_SYMBOLS);
  assign n_next = leaf_cnt_q + CNT_W'(room);
  assign leaf_d = cmd_i.first_leaf ? '0 : leaf_q + LEAF_W'(1);

  always_comb begin
    if (cmd_i.scan) rd_addr = idx_q;
    else if (cmd_i.walk) rd_addr = par_q;
    else rd_addr = NODE_W'(leaf_d);
  end
  assign rd_parent = parent_q[rd_addr];
  assign rd_weight = weight_mem[idx_q];
  assign rel       = par_q - NODE_W'(leaf_cnt_q);
  assign bit_v     = left_mem[rel[LEAF_W-1:0]] != child_q;

  assign status_o.build_done = !(((NODE_W+2)'(k_q) + (NODE_W+2)'(1)) <
                                 ((NODE_W+2)'(leaf_cnt_q) << 1));
  assign status_o.scan_last  = idx_q == (k_q - NODE_W'(1));
  assign status_o.at_root    = par_q == '0;
  assign status_o.last_leaf  = (CNT_W'(leaf_q) + CNT_W'(1)) == leaf_cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      weight_mem[leaf_cnt_q[LEAF_W-1:0]] <= SUM_W'(weight_i);
      sym_mem[leaf_cnt_q[LEAF_W-1:0]]    <= symbol_i;
    end else if (cmd_i.merge) begin
      weight_mem[k_q] <= wa_q + wb_q;
    end
    if (cmd_i.merge) begin
      left_mem[rel_k()] <= a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODE_COUNT; i++) parent_q[i] <= '0;
      leaf_cnt_q <= '0;
    end else begin
      if (cmd_i.load && room) begin
        parent_q[leaf_cnt_q[LEAF_W-1:0]] <= '0;
        leaf_cnt_q <= n_next;
      end
      if (cmd_i.merge) begin
        parent_q[a_q] <= k_q;
        parent_q[b_q] <= k_q;
      end
      if (cmd_i.finish) begin
        for (int i = 0; i < NODE_COUNT; i++) parent_q[i] <= '0;
        leaf_cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && last_symbol_i) begin
      k_q   <= NODE_W'(n_next);
      idx_q <= '0;
      ha_q  <= 1'b0;
      hb_q  <= 1'b0;
    end
    if (cmd_i.scan) begin
      idx_q <= idx_q + NODE_W'(1);
      if (rd_parent == '0) begin
        if (!ha_q || rd_weight < wa_q) begin
          b_q  <= a_q;
          wb_q <= wa_q;
          hb_q <= ha_q;
          a_q  <= idx_q;
          wa_q <= rd_weight;
          ha_q <= 1'b1;
        end else if (!hb_q || rd_weight < wb_q) begin
          b_q  <= idx_q;
          wb_q <= rd_weight;
          hb_q <= 1'b1;
        end
      end
    end
    if (cmd_i.merge) begin
      k_q   <= k_q + NODE_W'(1);
      idx_q <= '0;
      ha_q  <= 1'b0;
      hb_q  <= 1'b0;
    end
    if (cmd_i.first_leaf || cmd_i.next_leaf) begin
      leaf_q  <= leaf_d;
      child_q <= NODE_W'(leaf_d);
      par_q   <= rd_parent;
      code_q  <= '0;
      len_q   <= '0;
    end
    if (cmd_i.walk) begin
      if (len_q < LEN_W'(CODE_MAX_LEN)) begin
        code_q <= code_q | (CODE_W'(bit_v) << len_q);
        len_q  <= len_q + LEN_W'(1);
      end
      child_q <= par_q;
      par_q   <= rd_parent;
    end
  end

  assign out_symbol_o  = sym_mem[leaf_q];
  assign code_bits_o   = code_q;
  assign code_length_o = len_q;
  assign last_code_o   = status_o.last_leaf;

endmodule

// ===== design/huffman_code_table_builder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_table_builder: Huffman code table from symbol weights
// Send (symbol, weight) pairs on sym_i, one per cycle while ready is high;
// pairs beyond MAX_SYMBOLS are dropped. The pair with last_symbol set starts
// the build: sym_i.ready stays low until the whole table has been taken.
// For n leaves the build runs n-1 merges; the merge creating node k scans
// nodes 0..k-1 one per cycle through a single read port of the node store,
// then writes the merged node. Each code is then built by walking from its
// leaf to the root, one tree level per cycle, and is shown on code_o in load
// order until taken; last_code marks the final entry.
// A stalled receiver simply holds the entry and the walk of the next leaf.
// After the last entry the builder is empty and accepts a new set.
// Reset (rst_ni low) empties the leaf set and clears all parent links at
// once; the builder is ready on the first cycle after reset.
// A single symbol gets code length 0.
// ----------------------------------------------------------------------------
module huffman_code_table_builder import hctb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  hctb_sym_if.sink   sym_i,
  hctb_code_if.source code_o
);

  hctb_cmd_t    cmd;
  hctb_status_t status;

  hctb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sym_i.valid),
    .in_last_i   (sym_i.last_symbol),
    .in_ready_o  (sym_i.ready),
    .out_valid_o (code_o.valid),
    .out_ready_i (code_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hctb_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .symbol_i      (sym_i.symbol),
    .weight_i      (sym_i.weight),
    .last_symbol_i (sym_i.last_symbol),
    .out_symbol_o  (code_o.out_symbol),
    .code_bits_o   (code_o.code_bits),
    .code_length_o (code_o.code_length),
    .last_code_o   (code_o.last_code)
  );

`ifndef NO_ASSERTIONS
  a_no_load_while_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_o.valid |-> !sym_i.ready)
    else $error("input accepted while a code entry is pending");

  a_walk_after_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_o.valid && code_o.ready && !code_o.last_code |=> !code_o.valid)
    else $error("code entry repeated without a tree walk");

  a_ready_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_o.valid && code_o.ready && code_o.last_code |=> sym_i.ready)
    else $error("builder not emptied after final code");
`endif

endmodule

// ===== bench/tb_huffman_code_table_builder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_code_table_builder: self-checking bench of the code table builder
// Drives sets of (symbol, weight) pairs: a directed table with single, two-symbol
// and overfull sets, then random sets. A behavioral tree builder predicts each code
// table entry, and every received transaction is compared field by field.
// ----------------------------------------------------------------------------
module tb_huffman_code_table_builder;
  import hctb_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0]       symbol;
    logic [WEIGHT_BITS-1:0] weight;
    logic                   last_symbol;
  } pair_t;

  typedef struct packed {
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              last;
  } entry_t;

  typedef struct {
    pair_t  pair;
    logic   known;
    entry_t entry;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hctb_sym_if  sym_if ();
  hctb_code_if code_if ();

  huffman_code_table_builder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sym_i  (sym_if.sink),
    .code_o (code_if.source)
  );

  always #5 clk_i = ~clk_i;

  logic [SYM_W-1:0] leaf_sym [MAX_SYMBOLS];
  logic [SUM_W:0]   tree_wt  [NODE_COUNT];
  int               tree_par [NODE_COUNT];
  int               tree_lft [MAX_SYMBOLS];
  int               held;
  entry_t           code_q [$];
  entry_t           pinned_q [$];
  int               errors = 0;
  int               src_idle = 31;
  int               snk_idle = 73;
  longint           cycles = 0;

  task automatic report_mismatch(input string what, input entry_t got, input entry_t exp);
    $display({"ERROR %0t %s: got sym=%0d code=%0h len=%0d last=%0b",
              " exp sym=%0d code=%0h len=%0d last=%0b"},
             $realtime, what, got.symbol, got.code, got.len, got.last,
             exp.symbol, exp.code, exp.len, exp.last);
    errors++;
  endtask

  task automatic build_codes(input pair_t p);
    int n, a, b, c, par, len;
    logic [CODE_W-1:0] code;
    entry_t e;
    if (held < MAX_SYMBOLS) begin
      leaf_sym[held] = p.symbol;
      tree_wt[held]  = (SUM_W+1)'(p.weight);
      tree_par[held] = 0;
      held++;
    end
    if (!p.last_symbol) return;
    n = held;
    for (int k = n; k < 2 * n - 1; k++) begin
      a = -1;
      b = -1;
      for (int i = 0; i < k; i++)
        if (tree_par[i] == 0 && (a < 0 || tree_wt[i] < tree_wt[a])) a = i;
      for (int i = 0; i < k; i++)
        if (tree_par[i] == 0 && i != a && (b < 0 || tree_wt[i] < tree_wt[b])) b = i;
      tree_par[a] = k;
      tree_par[b] = k;
      tree_par[k] = 0;
      tree_lft[k - n] = a;
      tree_wt[k] = tree_wt[a] + tree_wt[b];
    end
    for (int i = 0; i < n; i++) begin
      c = i;
      par = tree_par[i];
      len = 0;
      code = '0;
      while (par != 0) begin
        if (len < CODE_MAX_LEN) begin
          code[len] = (tree_lft[par - n] == c) ? 1'b0 : 1'b1;
          len++;
        end
        c = par;
        par = tree_par[c];
      end
      e.symbol = leaf_sym[i];
      e.code = code;
      e.len = len[LEN_W-1:0];
      e.last = (i == n - 1);
      code_q.push_back(e);
    end
    for (int i = 0; i < NODE_COUNT; i++) tree_par[i] = 0;
    held = 0;
  endtask

  task automatic send_pair(input pair_t p);
    while ($urandom_range(99) < src_idle) begin
      sym_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sym_if.valid       <= 1'b1;
    sym_if.symbol      <= p.symbol;
    sym_if.weight      <= p.weight;
    sym_if.last_symbol <= p.last_symbol;
    do @(posedge clk_i); while (!sym_if.ready);
    build_codes(p);
  endtask

  task automatic idle_input();
    sym_if.valid <= 1'b0;
  endtask

  function automatic pair_t mk(input int s, input int w, input bit l);
    pair_t p;
    p.symbol = SYM_W'(s);
    p.weight = WEIGHT_BITS'(w);
    p.last_symbol = l;
    return p;
  endfunction

  function automatic entry_t ent(input int s, input int c, input int l, input bit t);
    entry_t e;
    e.symbol = SYM_W'(s);
    e.code = CODE_W'(c);
    e.len = LEN_W'(l);
    e.last = t;
    return e;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (code_if.valid && code_if.ready) begin
        entry_t got, exp;
        got = {code_if.out_symbol, code_if.code_bits, code_if.code_length, code_if.last_code};
        if (code_q.size() == 0) begin
          report_mismatch("unexpected", got, got);
        end else begin
          exp = code_q.pop_front();
          if (pinned_q.size() != 0 && got == pinned_q[0]) void'(pinned_q.pop_front());
          else if (pinned_q.size() != 0) report_mismatch("table", got, pinned_q.pop_front());
          if (got.symbol !== exp.symbol || got.code !== exp.code ||
              got.len !== exp.len || got.last !== exp.last)
            report_mismatch("mismatch", got, exp);
        end
      end
      code_if.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_set(input int n, input int wmax);
    pair_t p;
    for (int i = 0; i < n; i++) begin
      p = mk($urandom_range(255), $urandom_range(wmax), i == n - 1);
      if ($urandom_range(9) == 0) p.weight = WEIGHT_BITS'($urandom());
      send_pair(p);
    end
  endtask

  row_t rows [$];

  initial begin
    pair_t p;
    sym_if.valid = 1'b0;
    sym_if.symbol = '0;
    sym_if.weight = '0;
    sym_if.last_symbol = 1'b0;
    code_if.ready = 1'b0;
    held = 0;
    for (int i = 0; i < NODE_COUNT; i++) tree_par[i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    rows.push_back('{mk(8'hA5, 7, 1), 1'b1, ent(8'hA5, 0, 0, 1)});
    rows.push_back('{mk(8'h00, 0, 0), 1'b1, ent(8'h00, 0, 1, 0)});
    rows.push_back('{mk(8'hFF, 24'hFFFFFF, 1), 1'b1, ent(8'hFF, 1, 1, 1)});
    rows.push_back('{mk(8'h11, 5, 0), 1'b1, ent(8'h11, 0, 1, 0)});
    rows.push_back('{mk(8'h22, 5, 1), 1'b1, ent(8'h22, 1, 1, 1)});
    for (int i = 0; i < 18; i++)
      rows.push_back('{mk(i * 15, 24'hFFFFFF >> i, i == 17), 1'b0, ent(0, 0, 0, 0)});
    foreach (rows[r]) begin
      send_pair(rows[r].pair);
      if (rows[r].known) pinned_q.push_back(rows[r].entry);
    end

    for (int phase = 0; phase < 3; phase++) begin
      idle_input();
      wait (code_q.size() == 0);
      if (phase == 1) begin
        src_idle = 73;
        snk_idle = 31;
      end else if (phase == 2) begin
        src_idle = 0;
        snk_idle = 0;
      end
      for (int s = 0; s < 5; s++) begin
        send_set($urandom_range(1, 12), (s % 2) ? 3 : 24'hFFFFFF);
        if (s == 2) begin
          idle_input();
          wait (code_q.size() == 0);
        end
      end
      send_set(MAX_SYMBOLS + 2, 24'hFFFFFF);
    end
    p = mk(8'h5A, 9, 0);
    send_pair(p);
    send_pair(mk(8'hC3, 24'h800000, 1));

    idle_input();
    wait (code_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && code_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
